// ----- src/hto_pkg.sv -----
// Shared codes and field widths for the heap timer queue.
// No dependencies.
`timescale 1ns / 1ps
package hto_pkg;
    localparam int ID_W  = 6;
    localparam int NUM_IDS = 64;
    localparam int OCC_W = 7;
    localparam int MAX_POPS = 64;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_ADJUST = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_TICK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_PRESENT   = 2'd3
    } t_status;
endpackage

// ----- src/hto_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module hto_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/heap_timer_queue.sv -----
// Each heap level of a sift passes through S_UP_RD and S_UP_CMP going up and through S_DN_RDL,
// S_DN_RDR and S_DN_CMP going down, all on the single heap read port.
// Tick: each expiry is found by a root check in S_TK_RD and S_TK_CHK;
// an expiry also waits while the previous result is still held in the output register.
// One request in flight at a time. Reset (synchronous, active low) empties the queue
// and clears all id valid bits at once. Top level; uses hto_pkg and hto_ram.
`timescale 1ns / 1ps
module heap_timer_queue
    import hto_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int TIME_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_command,
    input  logic [ID_W-1:0]    i_timer_id,
    input  logic [31:0]        i_deadline,
    input  logic [31:0]        i_now_time,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic               o_expired_valid,
    output logic [ID_W-1:0]    o_expired_id,
    output logic [OCC_W-1:0]   o_occupancy,
    output logic               o_last
);
    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = SW + 2;
    localparam int TW = TIME_BITS;
    localparam int EW = ID_W + TW;
    localparam int KW = $clog2(MAX_POPS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_TAIL_RD, S_TAIL_D, S_UP_RD, S_UP_CMP,
        S_DN_RDL, S_DN_RDR, S_DN_CMP, S_PLACE, S_EMIT,
        S_TK_RD, S_TK_CHK, S_TK_POP, S_TK_FIN
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [TW-1:0]       r_now;
    logic [CW-1:0]       r_cnt;
    logic [SW-1:0]       r_pos;
    logic [ID_W-1:0]     r_eid;
    logic [TW-1:0]       r_ewhen;
    logic [ID_W-1:0]     r_lid;
    logic [TW-1:0]       r_lwhen;
    logic                r_hasr;
    logic                r_moved;
    logic                r_dn_ok;
    logic [NUM_IDS-1:0]  r_vld;
    logic [1:0]          r_st;
    logic                r_pend;
    logic [ID_W-1:0]     r_pid;
    logic [OCC_W-1:0]    r_pocc;
    logic [ID_W-1:0]     r_rid;
    logic [KW-1:0]       r_k;
    logic                r_ov;
    logic [1:0]          r_ostat;
    logic                r_oexp;
    logic [ID_W-1:0]     r_oid;
    logic [OCC_W-1:0]    r_oocc;
    logic                r_olast;

    // memory ports
    logic                h_we;
    logic [SW-1:0]       h_waddr, h_raddr;
    logic [EW-1:0]       h_wdata, h_rdata;
    logic                p_we;
    logic [ID_W-1:0]     p_waddr;
    logic [SW-1:0]       p_wdata, p_rdata;

    logic [ID_W-1:0]     rd_id;
    logic [TW-1:0]       rd_when;
    logic [SW-1:0]       w_parent;
    logic [XW-1:0]       w_left, w_right, w_cnt;
    logic                w_l_lt, w_r_lt, w_move;
    logic [TW-1:0]       w_min;
    logic                w_ofree;
    logic                w_oload;
    logic                w_in_acc;

    assign rd_id    = h_rdata[EW-1 -: ID_W];
    assign rd_when  = h_rdata[TW-1:0];
    assign w_parent = SW'((r_pos - SW'(1)) >> 1);
    assign w_left   = XW'({r_pos, 1'b1});
    assign w_right  = w_left + XW'(1);
    assign w_cnt    = XW'(r_cnt);

    // child selection for a step of the downward sift; left wins ties
    assign w_l_lt = r_lwhen < r_ewhen;
    assign w_min  = w_l_lt ? r_lwhen : r_ewhen;
    assign w_r_lt = r_hasr && (rd_when < w_min);
    assign w_move = w_l_lt || w_r_lt;

    assign w_ofree  = !r_ov || i_out_ready;
    // output register takes a new result this cycle
    assign w_oload  = w_ofree && ((r_state == S_EMIT) || (r_state == S_TK_FIN)
                      || ((r_state == S_TK_POP) && r_pend));
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc = i_in_valid && o_in_ready;

    hto_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
        .i_clk  (i_clk),
        .i_we   (h_we),
        .i_waddr(h_waddr),
        .i_wdata(h_wdata),
        .i_raddr(h_raddr),
        .o_rdata(h_rdata)
    );

    hto_ram #(.WIDTH(SW), .DEPTH(NUM_IDS)) u_pmap (
        .i_clk  (i_clk),
        .i_we   (p_we),
        .i_waddr(p_waddr),
        .i_wdata(p_wdata),
        .i_raddr(i_timer_id),
        .o_rdata(p_rdata)
    );

    // memory address and write control per state
    always_comb begin
        h_raddr = '0;
        h_we    = 1'b0;
        h_waddr = r_pos;
        h_wdata = {r_eid, r_ewhen};
        p_we    = 1'b0;
        p_waddr = r_eid;
        p_wdata = r_pos;
        case (r_state)
            S_TAIL_RD: h_raddr = r_cnt[SW-1:0];
            S_UP_RD:   h_raddr = w_parent;
            S_UP_CMP: begin
                if (r_ewhen < rd_when) begin
                    h_we    = 1'b1;
                    h_wdata = h_rdata;
                    p_we    = 1'b1;
                    p_waddr = rd_id;
                end
            end
            S_DN_RDL:  h_raddr = w_left[SW-1:0];
            S_DN_RDR:  h_raddr = w_right[SW-1:0];
            S_DN_CMP: begin
                if (w_move) begin
                    h_we    = 1'b1;
                    h_wdata = w_r_lt ? h_rdata : {r_lid, r_lwhen};
                    p_we    = 1'b1;
                    p_waddr = w_r_lt ? rd_id : r_lid;
                end
            end
            S_PLACE: begin
                h_we = 1'b1;
                p_we = 1'b1;
            end
            default: h_raddr = '0;
        endcase
    end

    // sequencer, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_vld   <= '0;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            if (r_ov && i_out_ready && !w_oload) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_cmd   <= t_cmd'(i_command);
                        r_now   <= TW'(i_now_time);
                        r_eid   <= i_timer_id;
                        r_ewhen <= TW'(i_deadline);
                        r_st    <= ST_OK;
                        r_moved <= 1'b0;
                        case (t_cmd'(i_command))
                            CMD_TICK: begin
                                r_k    <= '0;
                                r_pend <= 1'b0;
                                r_state <= S_TK_RD;
                            end
                            CMD_ADD: begin
                                if (r_vld[i_timer_id]) begin
                                    r_st    <= ST_PRESENT;
                                    r_state <= S_EMIT;
                                end else if (r_cnt >= CW'(CAPACITY)) begin
                                    r_st    <= ST_FULL;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_pos   <= r_cnt[SW-1:0];
                                    r_cnt   <= r_cnt + CW'(1);
                                    r_vld[i_timer_id] <= 1'b1;
                                    r_dn_ok <= 1'b0;
                                    r_state <= S_UP_RD;
                                end
                            end
                            default: begin
                                if (!r_vld[i_timer_id]) begin
                                    r_st    <= ST_NOT_FOUND;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= S_LOOK;
                                end
                            end
                        endcase
                    end
                end
                S_LOOK: begin
                    r_pos   <= p_rdata;
                    r_dn_ok <= 1'b1;
                    if (r_cmd == CMD_ADJUST) begin
                        r_state <= S_UP_RD;
                    end else begin
                        // delete: tail fills the hole unless the hole is the tail
                        r_vld[r_eid] <= 1'b0;
                        r_cnt <= r_cnt - CW'(1);
                        if (CW'(p_rdata) == r_cnt - CW'(1)) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_TAIL_RD;
                        end
                    end
                end
                S_TAIL_RD: r_state <= S_TAIL_D;
                S_TAIL_D: begin
                    r_eid   <= rd_id;
                    r_ewhen <= rd_when;
                    r_state <= S_UP_RD;
                end
                S_UP_RD: begin
                    if (r_pos == '0) begin
                        r_state <= (r_dn_ok && !r_moved) ? S_DN_RDL : S_PLACE;
                    end else begin
                        r_state <= S_UP_CMP;
                    end
                end
                S_UP_CMP: begin
                    if (r_ewhen < rd_when) begin
                        r_pos   <= w_parent;
                        r_moved <= 1'b1;
                        r_state <= S_UP_RD;
                    end else begin
                        r_state <= (r_dn_ok && !r_moved) ? S_DN_RDL : S_PLACE;
                    end
                end
                S_DN_RDL: begin
                    r_state <= (w_left >= w_cnt) ? S_PLACE : S_DN_RDR;
                end
                S_DN_RDR: begin
                    r_lid   <= rd_id;
                    r_lwhen <= rd_when;
                    r_hasr  <= w_right < w_cnt;
                    r_state <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (w_move) begin
                        r_pos   <= w_r_lt ? w_right[SW-1:0] : w_left[SW-1:0];
                        r_state <= S_DN_RDL;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    r_state <= (r_cmd == CMD_TICK) ? S_TK_RD : S_EMIT;
                end
                S_EMIT: begin
                    if (w_ofree) begin
                        r_ov    <= 1'b1;
                        r_ostat <= r_st;
                        r_oexp  <= 1'b0;
                        r_oid   <= '0;
                        r_oocc  <= OCC_W'(r_cnt);
                        r_olast <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_TK_RD: begin
                    if (r_cnt == '0 || r_k == KW'(MAX_POPS)) begin
                        r_state <= S_TK_FIN;
                    end else begin
                        r_state <= S_TK_CHK;
                    end
                end
                S_TK_CHK: begin
                    r_rid   <= rd_id;
                    r_state <= (rd_when <= r_now) ? S_TK_POP : S_TK_FIN;
                end
                S_TK_POP: begin
                    if (!r_pend || w_ofree) begin
                        // the previous pop is now known not to be the last one
                        if (r_pend) begin
                            r_ov    <= 1'b1;
                            r_ostat <= ST_OK;
                            r_oexp  <= 1'b1;
                            r_oid   <= r_pid;
                            r_oocc  <= r_pocc;
                            r_olast <= 1'b0;
                        end
                        r_pend  <= 1'b1;
                        r_pid   <= r_rid;
                        r_pocc  <= OCC_W'(r_cnt - CW'(1));
                        r_vld[r_rid] <= 1'b0;
                        r_cnt   <= r_cnt - CW'(1);
                        r_k     <= r_k + KW'(1);
                        r_pos   <= '0;
                        r_moved <= 1'b0;
                        r_dn_ok <= 1'b1;
                        r_state <= (r_cnt == CW'(1)) ? S_TK_RD : S_TAIL_RD;
                    end
                end
                S_TK_FIN: begin
                    if (w_ofree) begin
                        r_ov    <= 1'b1;
                        r_ostat <= ST_OK;
                        r_oexp  <= r_pend;
                        r_oid   <= r_pend ? r_pid : '0;
                        r_oocc  <= r_pend ? r_pocc : OCC_W'(r_cnt);
                        r_olast <= 1'b1;
                        r_pend  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_ov;
    assign o_status        = r_ostat;
    assign o_expired_valid = r_oexp;
    assign o_expired_id    = r_oid;
    assign o_occupancy     = r_oocc;
    assign o_last          = r_olast;
endmodule

// ----- src/hto_check.sv -----
// Port-level checks for the heap timer queue, bound to the top level.
// Uses hto_pkg.
`timescale 1ns / 1ps
module hto_check
    import hto_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [1:0]       o_status,
    input logic             o_expired_valid,
    input logic [ID_W-1:0]  o_expired_id,
    input logic [OCC_W-1:0] o_occupancy,
    input logic             o_last
);
    // an empty result carries no id
    a_empty_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_expired_valid) |-> (o_expired_id == '0))
        else $error("empty result carries an id");

    // expiries are always reported with status ok
    a_exp_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_expired_valid) |-> (o_status == ST_OK))
        else $error("expiry with non-ok status");

    // only expiries of a tick can be followed by more results
    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> o_expired_valid)
        else $error("non-final result that is not an expiry");

    // a stalled result stays valid and holds its id and occupancy
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_expired_id)
            && $stable(o_occupancy)))
        else $error("result changed while stalled");
endmodule

bind heap_timer_queue hto_check #(.CAPACITY(CAPACITY)) u_hto_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_expired_valid(o_expired_valid),
    .o_expired_id   (o_expired_id),
    .o_occupancy    (o_occupancy),
    .o_last         (o_last)
);

// ----- tb/sv/heap_timer_queue_tb.sv -----
// Self-checking testbench for heap_timer_queue: directed and random timer requests,
// results predicted by an in-bench indexed min-heap and compared field by field.
// Depends on hto_pkg and the heap_timer_queue RTL.
`timescale 1ns / 1ps
module heap_timer_queue_tb;
    import hto_pkg::*;

    localparam int CAP = 64;

    typedef struct packed {
        logic [1:0]      status;
        logic            exp_valid;
        logic [ID_W-1:0] exp_id;
        logic [OCC_W-1:0] occ;
        logic            last;
    } t_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [1:0]        i_command;
    logic [ID_W-1:0]   i_timer_id;
    logic [31:0]       i_deadline;
    logic [31:0]       i_now_time;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [1:0]        o_status;
    logic              o_expired_valid;
    logic [ID_W-1:0]   o_expired_id;
    logic [OCC_W-1:0]  o_occupancy;
    logic              o_last;

    heap_timer_queue #(.CAPACITY(CAP), .TIME_BITS(32)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_command(i_command), .i_timer_id(i_timer_id),
        .i_deadline(i_deadline), .i_now_time(i_now_time),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_status(o_status), .o_expired_valid(o_expired_valid),
        .o_expired_id(o_expired_id), .o_occupancy(o_occupancy), .o_last(o_last)
    );

    // Predictor state: shadow heap of {id, deadline} and id->slot map
    logic [ID_W-1:0] sh_id [CAP];
    logic [31:0]     sh_when [CAP];
    int              slot_of [NUM_IDS];
    bit              id_live [NUM_IDS];
    int              timer_cnt;

    t_result pending_results[$];
    int      n_errors;
    int      n_sent;
    int      n_checked;
    int      n_expired;
    bit      hold_off;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // append one expected result at the tail of the queue
    function automatic void expect_result(t_result r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [ID_W-1:0] tid;
        logic [31:0]     tw;
        tid = sh_id[a]; tw = sh_when[a];
        sh_id[a] = sh_id[b]; sh_when[a] = sh_when[b];
        sh_id[b] = tid; sh_when[b] = tw;
        slot_of[sh_id[a]] = a;
        slot_of[sh_id[b]] = b;
    endfunction

    function automatic void sift_up(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (sh_when[i] >= sh_when[p]) break;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    function automatic void sink_slot(int i);
        int best;
        int l;
        int r;
        forever begin
            best = i;
            l = 2 * i + 1;
            r = 2 * i + 2;
            if (l < timer_cnt && sh_when[l] < sh_when[best]) best = l;
            if (r < timer_cnt && sh_when[r] < sh_when[best]) best = r;
            if (best == i) break;
            swap_slots(i, best);
            i = best;
        end
    endfunction

    function automatic void remove_slot(int i);
        id_live[sh_id[i]] = 1'b0;
        timer_cnt--;
        if (i != timer_cnt) begin
            sh_id[i] = sh_id[timer_cnt];
            sh_when[i] = sh_when[timer_cnt];
            slot_of[sh_id[i]] = i;
            sift_up(i);
            sink_slot(i);
        end
    endfunction

    function automatic t_result mk(t_status st, bit v, logic [ID_W-1:0] id, bit lst);
        t_result r;
        r.status = st; r.exp_valid = v; r.exp_id = id;
        r.occ = timer_cnt[OCC_W-1:0]; r.last = lst;
        return r;
    endfunction

    // Apply one request to the shadow heap and queue the results it causes
    function automatic void predict_timer_op(t_cmd cmd, logic [ID_W-1:0] id,
                                             logic [31:0] dl, logic [31:0] now);
        t_status st;
        int      i;
        int      k;
        logic [ID_W-1:0] gone;
        st = ST_OK;
        if (cmd == CMD_TICK) begin
            k = 0;
            while (timer_cnt > 0 && sh_when[0] <= now) begin
                gone = sh_id[0];
                remove_slot(0);
                expect_result(mk(ST_OK, 1'b1, gone, 1'b0));
                k++;
                n_expired++;
            end
            if (k == 0) expect_result(mk(ST_OK, 1'b0, '0, 1'b1));
            else pending_results[$].last = 1'b1;
            return;
        end
        if (cmd == CMD_ADD) begin
            if (id_live[id]) st = ST_PRESENT;
            else if (timer_cnt >= CAP) st = ST_FULL;
            else begin
                i = timer_cnt;
                sh_id[i] = id; sh_when[i] = dl;
                slot_of[id] = i; id_live[id] = 1'b1;
                timer_cnt++;
                sift_up(i);
            end
        end else if (!id_live[id] || slot_of[id] >= timer_cnt) begin
            st = ST_NOT_FOUND;
        end else if (cmd == CMD_ADJUST) begin
            i = slot_of[id];
            sh_when[i] = dl;
            sift_up(i);
            if (slot_of[id] == i) sink_slot(i);
        end else begin
            remove_slot(slot_of[id]);
        end
        expect_result(mk(st, 1'b0, '0, 1'b1));
    endfunction

    // Drive one request; gap drawn per item, valid held until accepted
    task automatic send_request(t_cmd cmd, logic [ID_W-1:0] id, logic [31:0] dl,
                                logic [31:0] now, bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_timer_id <= id;
        i_deadline <= dl;
        i_now_time <= now;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_timer_op(cmd, id, dl, now);
        n_sent++;
        @(negedge i_clk);
    endtask

    // Result checker: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status=%0d id=%0d", o_status, o_expired_id);
                n_errors++;
            end else begin
                e = pending_results.pop_front();
                n_checked++;
                if (o_status !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, o_status); n_errors++;
                end
                if (o_expired_valid !== e.exp_valid) begin
                    $error("expired_valid: expected %0d actual %0d", e.exp_valid,
                           o_expired_valid); n_errors++;
                end
                if (o_expired_id !== e.exp_id) begin
                    $error("expired_id: expected %0d actual %0d", e.exp_id, o_expired_id);
                    n_errors++;
                end
                if (o_occupancy !== e.occ) begin
                    $error("occupancy: expected %0d actual %0d", e.occ, o_occupancy);
                    n_errors++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %0d actual %0d", e.last, o_last); n_errors++;
                end
            end
        end
    end

    // Receiver stall: random per result, or a long hold-off on request
    initial begin
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_ready <= 1'b0;
            end else if (o_out_valid && i_out_ready) begin
                i_out_ready <= 1'b0;
            end else if (!i_out_ready) begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
                repeat (stall) @(negedge i_clk);
                if (!hold_off) i_out_ready <= 1'b1;
            end
        end
    end

    task automatic test_basic_ops;
        send_request(CMD_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF);     // empty tick
        send_request(CMD_ADJUST, 6'd5, 32'd10, 32'd0);           // absent id
        send_request(CMD_DELETE, 6'd63, 32'd0, 32'd0);
        send_request(CMD_ADD, 6'd0, 32'hFFFF_FFFF, 32'd0);
        send_request(CMD_ADD, 6'd63, 32'd0, 32'd0);
        send_request(CMD_ADD, 6'd63, 32'd5, 32'd0);              // already present
        send_request(CMD_ADD, 6'd10, 32'd100, 32'd0);
        send_request(CMD_ADD, 6'd11, 32'd100, 32'd0);            // equal deadline
        send_request(CMD_ADD, 6'd12, 32'd50, 32'd0);
        send_request(CMD_ADJUST, 6'd10, 32'd1, 32'd0);           // stays in place
        send_request(CMD_ADJUST, 6'd63, 32'd200, 32'd0);         // moves down
        send_request(CMD_DELETE, 6'd12, 32'd0, 32'd0);
        send_request(CMD_TICK, 6'd0, 32'd0, 32'd0);              // expires nothing
        send_request(CMD_TICK, 6'd0, 32'd0, 32'd100);            // several at once
        send_request(CMD_DELETE, 6'd11, 32'd0, 32'd0);           // already expired
        send_request(CMD_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF);      // drains queue
    endtask

    // Fill to capacity, add a live id, delete and re-add three, then expire all 64 in one tick
    task automatic test_full_queue;
        for (int k = 0; k < CAP; k++)
            send_request(CMD_ADD, k[ID_W-1:0], $urandom_range(0, 1000), 32'd0, 1'b1);
        send_request(CMD_ADD, 6'd7, 32'd0, 32'd0);               // present
        for (int k = 0; k < 3; k++) send_request(CMD_DELETE, k[ID_W-1:0], 32'd0, 32'd0);
        for (int k = 0; k < 3; k++)
            send_request(CMD_ADD, k[ID_W-1:0], 32'hFFFF_FFFF, 32'd0);
        send_request(CMD_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF);
    endtask

    // Receiver holds off while requests keep coming, so the block backs up
    task automatic test_backpressure;
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 8; k++)
                send_request(CMD_ADD, ID_W'(k + 20), $urandom(), 32'd0, 1'b1);
        join
    endtask

    // Random mix: ids from 0 to 15 half the time, deadlines and times mostly in low bands
    task automatic test_random_mix;
        t_cmd cmd;
        logic [ID_W-1:0] id;
        logic [31:0] dl;
        logic [31:0] now;
        int sel;
        for (int n = 0; n < 35; n++) begin
            sel = $urandom_range(0, 9);
            cmd = (sel < 4) ? CMD_ADD : (sel < 6) ? CMD_ADJUST :
                  (sel < 8) ? CMD_DELETE : CMD_TICK;
            id = ($urandom_range(0, 1)) ? ID_W'($urandom_range(0, 15)) : ID_W'($urandom());
            dl = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 2000);
            now = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 1500);
            send_request(cmd, id, dl, now);
        end
        send_request(CMD_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF);
    endtask

    initial begin
        int wait_cnt;
        for (int k = 0; k < NUM_IDS; k++) begin
            id_live[k] = 1'b0;
            slot_of[k] = 0;
        end
        timer_cnt = 0; n_errors = 0; n_sent = 0; n_checked = 0; n_expired = 0;
        hold_off = 1'b0;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_command = CMD_ADD;
        i_timer_id = '0; i_deadline = '0; i_now_time = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_basic_ops();
        test_full_queue();
        test_backpressure();
        test_random_mix();
        i_in_valid <= 1'b0;

        wait_cnt = 0;
        while (pending_results.size() != 0 && wait_cnt < 200000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (50) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            n_errors++;
        end
        $display("Ran %0d requests, checked %0d results, %0d timers expired by tick.",
                 n_sent, n_checked, n_expired);
        if (n_errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
